// ===== sv/sldf_pkg.sv =====
// shared types and constants for the song loop detector and fade stop block
package sldf_pkg;

  localparam int POS_W       = 8;
  localparam int ORDER_BITS  = 8;
  localparam int ROW_BITS    = 8;
  localparam int CNT_W       = 32;
  localparam int TARGET_W    = 16;
  localparam int RATE_W      = 8;
  localparam int FADE_W      = 16;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int PROD_W      = TARGET_W + RATE_W;

  // visited tags: an entry is visited when its tag equals the current epoch
  localparam int                 EPOCH_BITS  = 8;
  localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(60);

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE    = 2'd0,
    MODE_LOOPS   = 2'd1,
    MODE_FRAMES  = 2'd2,
    MODE_SECONDS = 2'd3
  } stop_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_MODE   = 2'd0,
    CFG_STOP_TARGET = 2'd1,
    CFG_FRAME_RATE  = 2'd2,
    CFG_FADE_LENGTH = 2'd3
  } cfg_index_t;

  typedef struct packed {
    stop_mode_t          mode;
    logic [TARGET_W-1:0] target;
    logic [RATE_W-1:0]   rate;
    logic [FADE_W-1:0]   fade_len;
  } cfg_t;

  // sequencer to frame control
  typedef struct packed {
    logic accept;
    logic exec;
    logic playing;
    logic tag_match;
  } step_t;

  // frame control back to sequencer
  typedef struct packed {
    logic lookup;
    logic hit;
  } status_t;

endpackage

// ===== sv/song_loop_detect_and_fade_stop.sv =====
// top level: request sequencer, config registers and visited memory sweep
//
//  channel  signals                                        direction
//  -------  ---------------------------------------------  ---------
//  in       start, busy, in_playing, in_order_pos/row_pos  request in
//  out      out_valid, out_stop, out_fade_*, out_loops_... result out
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data      write in
//
// a request is accepted in ST_IDLE, which reads the visited tag memory, then
// ST_EXEC applies the frame update and registers the result.
// reset starts a sweep that clears all 2**(ORDER_BITS+ROW_BITS) tag entries,
// one a cycle with busy high; every 255th loop detected starts the same sweep
// again when the epoch counter wraps.
// results are strobed for one cycle; the receiver cannot stall.
module song_loop_detect_and_fade_stop #(
  parameter int ORDER_BITS = sldf_pkg::ORDER_BITS,
  parameter int ROW_BITS   = sldf_pkg::ROW_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_playing,
  input  logic [sldf_pkg::POS_W-1:0]      in_order_pos,
  input  logic [sldf_pkg::POS_W-1:0]      in_row_pos,
  output logic                            out_valid,
  output logic                            out_stop,
  output logic                            out_fade_active,
  output logic [sldf_pkg::FADE_W-1:0]     out_fade_level,
  output logic [sldf_pkg::CNT_W-1:0]      out_loops_seen,
  output logic [sldf_pkg::CNT_W-1:0]      out_frames_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sldf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sldf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int KEY_BITS   = ORDER_BITS + ROW_BITS;
  localparam int EPOCH_BITS = sldf_pkg::EPOCH_BITS;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_CLEAR = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  sldf_pkg::cfg_t        cfg_r;
  logic [KEY_BITS-1:0]   key_r;
  logic                  playing_r;
  logic [EPOCH_BITS-1:0] epoch_r, epoch_nxt;
  logic [KEY_BITS-1:0]   sweep_r;
  logic                  mark_r, mark_nxt;

  logic                  accept;
  logic [KEY_BITS-1:0]   in_key;
  logic [EPOCH_BITS-1:0] rd_tag;
  logic                  wr_en;
  logic [KEY_BITS-1:0]   wr_addr;
  logic [EPOCH_BITS-1:0] wr_data;
  logic                  wrap;
  sldf_pkg::step_t       step;
  sldf_pkg::status_t     status;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign in_key    = {in_order_pos[ORDER_BITS-1:0], in_row_pos[ROW_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= sldf_pkg::MODE_NONE;
      cfg_r.target   <= '0;
      cfg_r.rate     <= sldf_pkg::RATE_RESET;
      cfg_r.fade_len <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sldf_pkg::CFG_STOP_MODE:
          cfg_r.mode <= sldf_pkg::stop_mode_t'(cfg_data[sldf_pkg::MODE_W-1:0]);
        sldf_pkg::CFG_STOP_TARGET: cfg_r.target   <= cfg_data[sldf_pkg::TARGET_W-1:0];
        sldf_pkg::CFG_FRAME_RATE:  cfg_r.rate     <= cfg_data[sldf_pkg::RATE_W-1:0];
        sldf_pkg::CFG_FADE_LENGTH: cfg_r.fade_len <= cfg_data[sldf_pkg::FADE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r     <= in_key;
      playing_r <= in_playing;
    end
  end

  assign step.accept    = accept;
  assign step.exec      = (state_r == ST_EXEC);
  assign step.playing   = playing_r;
  assign step.tag_match = (rd_tag == epoch_r);

  // a loop clears the map by moving to a new epoch; the last epoch forces a sweep
  assign wrap = status.hit && (epoch_r == sldf_pkg::EPOCH_LAST);

  always_comb begin
    state_nxt = state_r;
    epoch_nxt = epoch_r;
    mark_nxt  = mark_r;
    wr_en     = 1'b0;
    wr_addr   = key_r;
    wr_data   = epoch_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (wrap) begin
          state_nxt = ST_CLEAR;
          epoch_nxt = sldf_pkg::EPOCH_FIRST;
          mark_nxt  = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
          wr_en     = status.lookup;
          if (status.hit) begin
            epoch_nxt = epoch_r + EPOCH_BITS'(1);
            wr_data   = epoch_r + EPOCH_BITS'(1);
          end
        end
      end
      ST_CLEAR: begin
        // the key that caused the sweep stays marked in the fresh epoch
        wr_en   = 1'b1;
        wr_addr = sweep_r;
        wr_data = (mark_r && sweep_r == key_r) ? sldf_pkg::EPOCH_FIRST
                                               : sldf_pkg::EPOCH_NONE;
        if (sweep_r == '1) begin
          state_nxt = ST_IDLE;
          mark_nxt  = 1'b0;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      epoch_r <= sldf_pkg::EPOCH_FIRST;
      mark_r  <= 1'b0;
      sweep_r <= '0;
    end else begin
      state_r <= state_nxt;
      epoch_r <= epoch_nxt;
      mark_r  <= mark_nxt;
      sweep_r <= (state_r == ST_CLEAR) ? sweep_r + KEY_BITS'(1) : '0;
    end
  end

  // the write of one request lands before the next accept edge reads
  sldf_visit_mem #(
    .ADDR_BITS (KEY_BITS),
    .DATA_BITS (EPOCH_BITS)
  ) u_visit_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_key),
    .rd_data (rd_tag),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  sldf_frame_ctrl #(
    .KEY_BITS (KEY_BITS)
  ) u_frame_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .step            (step),
    .key             (key_r),
    .status          (status),
    .out_valid       (out_valid),
    .out_stop        (out_stop),
    .out_fade_active (out_fade_active),
    .out_fade_level  (out_fade_level),
    .out_loops_seen  (out_loops_seen),
    .out_frames_done (out_frames_done)
  );

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && accept |=> state_r == ST_EXEC)
    else $error("accepted request did not reach the update step");

  a_single_exec: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && state_r == ST_EXEC |=> state_r != ST_EXEC)
    else $error("update step repeated");

  a_wrap_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && state_r == ST_EXEC && wrap |=> state_r == ST_CLEAR && epoch_r == sldf_pkg::EPOCH_FIRST)
    else $error("epoch wrap did not start a clearing sweep");

  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && state_r == ST_EXEC && !wrap && status.hit |=> epoch_r == $past(epoch_r) + EPOCH_BITS'(1))
    else $error("loop did not advance the epoch");

endmodule

// ===== sv/sldf_visit_mem.sv =====
// visited tag memory, one write port and one registered read port
module sldf_visit_mem #(
  parameter int ADDR_BITS = sldf_pkg::ORDER_BITS + sldf_pkg::ROW_BITS,
  parameter int DATA_BITS = sldf_pkg::EPOCH_BITS
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/sldf_frame_ctrl.sv =====
// per-frame counters, fade timer, stop rule and result registers
module sldf_frame_ctrl #(
  parameter int KEY_BITS = sldf_pkg::ORDER_BITS + sldf_pkg::ROW_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sldf_pkg::cfg_t              cfg,
  input  sldf_pkg::step_t             step,
  input  logic [KEY_BITS-1:0]         key,
  output sldf_pkg::status_t           status,
  output logic                        out_valid,
  output logic                        out_stop,
  output logic                        out_fade_active,
  output logic [sldf_pkg::FADE_W-1:0] out_fade_level,
  output logic [sldf_pkg::CNT_W-1:0]  out_loops_seen,
  output logic [sldf_pkg::CNT_W-1:0]  out_frames_done
);

  localparam int CNT_W  = sldf_pkg::CNT_W;
  localparam int FADE_W = sldf_pkg::FADE_W;
  localparam int PROD_W = sldf_pkg::PROD_W;

  logic [KEY_BITS-1:0] last_pos_r;
  logic                last_valid_r;
  logic [CNT_W-1:0]    loop_r, loop_nxt;
  logic [CNT_W-1:0]    frame_r;
  logic                fading_r, fading_nxt;
  logic [FADE_W-1:0]   timer_r, timer_nxt;
  logic [CNT_W-1:0]    fade_start_r, fade_start_nxt;

  // operands prepared at accept, state is stable then
  logic [CNT_W-1:0]    loop_inc_r;
  logic [CNT_W-1:0]    frame_inc_r;
  logic [PROD_W-1:0]   prod_r;
  logic [CNT_W:0]      fade_end_r;

  logic                out_valid_r, out_stop_r, out_fade_active_r;
  logic [FADE_W-1:0]   out_fade_level_r;
  logic [CNT_W-1:0]    out_loops_r, out_frames_r;

  logic                gain_on;
  logic [FADE_W-1:0]   level;
  logic                cond;
  logic                start_fade;
  logic                stop;

  assign status.lookup = last_valid_r && (key != last_pos_r);
  assign status.hit    = status.lookup && step.tag_match;

  always_comb begin
    gain_on   = fading_r && (cfg.fade_len != '0);
    level     = gain_on ? timer_r : '0;
    timer_nxt = (gain_on && timer_r != '0) ? timer_r - FADE_W'(1) : timer_r;
    loop_nxt  = status.hit ? loop_inc_r : loop_r;

    unique case (cfg.mode)
      sldf_pkg::MODE_LOOPS:   cond = loop_nxt >= CNT_W'(cfg.target);
      sldf_pkg::MODE_FRAMES:  cond = frame_inc_r >= CNT_W'(cfg.target);
      sldf_pkg::MODE_SECONDS: cond = frame_inc_r >= CNT_W'(prod_r);
      default:                cond = 1'b0;
    endcase

    start_fade     = step.playing && cond && !fading_r;
    fading_nxt     = fading_r;
    fade_start_nxt = fade_start_r;
    if (start_fade) begin
      fading_nxt     = 1'b1;
      timer_nxt      = cfg.fade_len;
      fade_start_nxt = frame_inc_r;
    end

    // a fade starting now ends at once only when its length is zero
    if (!step.playing) begin
      stop = 1'b1;
    end else if (start_fade) begin
      stop = (cfg.fade_len == '0);
    end else begin
      stop = fading_r && ({1'b0, frame_inc_r} >= fade_end_r);
    end
  end

  always_ff @(posedge clk) begin
    if (step.accept) begin
      loop_inc_r  <= (loop_r == '1) ? loop_r : loop_r + CNT_W'(1);
      frame_inc_r <= (frame_r == '1) ? frame_r : frame_r + CNT_W'(1);
      prod_r      <= PROD_W'(cfg.target) * PROD_W'(cfg.rate);
      fade_end_r  <= {1'b0, fade_start_r} + (CNT_W + 1)'(cfg.fade_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r   <= '0;
      last_valid_r <= 1'b0;
      loop_r       <= '0;
      frame_r      <= '0;
      fading_r     <= 1'b0;
      timer_r      <= '0;
      fade_start_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= step.exec;
      if (step.exec) begin
        last_pos_r   <= key;
        last_valid_r <= 1'b1;
        loop_r       <= loop_nxt;
        frame_r      <= frame_inc_r;
        fading_r     <= fading_nxt;
        timer_r      <= timer_nxt;
        fade_start_r <= fade_start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step.exec) begin
      out_stop_r        <= stop;
      out_fade_active_r <= fading_r;
      out_fade_level_r  <= level;
      out_loops_r       <= loop_nxt;
      out_frames_r      <= frame_inc_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_stop        = out_stop_r;
  assign out_fade_active = out_fade_active_r;
  assign out_fade_level  = out_fade_level_r;
  assign out_loops_seen  = out_loops_r;
  assign out_frames_done = out_frames_r;

  // a result follows every frame step in the next cycle, and nothing else
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) || out_valid_r == $past(step.exec))
    else $error("result strobe not aligned with frame step");

  // counters never run backwards across a frame
  a_frames_grow: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && step.exec |=> frame_r >= $past(frame_r))
    else $error("frame counter went backwards");

  // a fade once running stays running
  a_fade_holds: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && fading_r |=> fading_r)
    else $error("fade flag dropped");

endmodule
